[rtl/tria_pkg.sv]
`default_nettype none
package tria_pkg;
  localparam int MaxIntervalsDef = 64;
  localparam int TimeBitsDef = 16;
endpackage
`default_nettype wire

[rtl/tria_if.sv]
`default_nettype none
interface tria_in_if #(parameter int TimeBits = 16);
  logic valid;
  logic ready;
  logic [TimeBits-1:0] start_time;
  logic [TimeBits-1:0] end_time;
  logic last_interval;
  modport source(output valid, start_time, end_time, last_interval, input ready);
  modport sink(input valid, start_time, end_time, last_interval, output ready);
endinterface

interface tria_out_if;
  logic valid;
  logic ready;
  logic owner;
  logic impossible;
  logic last_result;
  modport source(output valid, owner, impossible, last_result, input ready);
  modport sink(input valid, owner, impossible, last_result, output ready);
endinterface
`default_nettype wire

[rtl/tria_cell.sv]
`default_nettype none
module tria_cell
  import tria_pkg::*;
#(
  parameter int TimeBits = TimeBitsDef,
  parameter int IdxBits = 6
) (
  input  wire logic                clk,
  input  wire logic                ins,
  input  wire logic                shift,
  input  wire logic [TimeBits-1:0] new_start,
  input  wire logic [TimeBits-1:0] new_end,
  input  wire logic [IdxBits-1:0]  new_idx,
  input  wire logic                prev_goes_after,
  input  wire logic [TimeBits-1:0] prev_start,
  input  wire logic [TimeBits-1:0] prev_end,
  input  wire logic [IdxBits-1:0]  prev_idx,
  input  wire logic                prev_valid,
  input  wire logic [TimeBits-1:0] next_start,
  input  wire logic [TimeBits-1:0] next_end,
  input  wire logic [IdxBits-1:0]  next_idx,
  input  wire logic                valid,
  output logic                     goes_after,
  output logic [TimeBits-1:0]      start_r,
  output logic [TimeBits-1:0]      end_r,
  output logic [IdxBits-1:0]       idx_r
);
  logic new_first;
  assign new_first = (new_start < start_r) || (new_start == start_r && new_end < end_r);
  assign goes_after = valid && new_first;
  always_ff @(posedge clk) begin
    if (shift) begin
      start_r <= next_start;
      end_r <= next_end;
      idx_r <= next_idx;
    end else if (ins && (goes_after || !valid)) begin
      if (prev_goes_after && prev_valid) begin
        start_r <= prev_start;
        end_r <= prev_end;
        idx_r <= prev_idx;
      end else begin
        start_r <= new_start;
        end_r <= new_end;
        idx_r <= new_idx;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/two_resource_interval_assigner.sv]
`default_nettype none
// Channel | Dir | Payload
// in_     | in  | start_time, end_time, last_interval
// out_    | out | owner, impossible, last_result
// Each accepted request is inserted into a sorted chain of cells as it is taken.
// After the last request the chain shifts one interval per cycle into the greedy unit,
// then N results stream out for N stored intervals (one when impossible or when none
// are stored), one per cycle while out_ready is high.
// Reset is synchronous and clears counts and control; stored intervals are not cleared.
// The input stalls during the pass and while results are delivered.
module two_resource_interval_assigner
  import tria_pkg::*;
#(
  parameter int MaxIntervals = MaxIntervalsDef,
  parameter int TimeBits = TimeBitsDef
) (
  input wire logic  clk,
  input wire logic  rst_n,
  tria_in_if.sink   in_ch,
  tria_out_if.source out_ch
);
  localparam int IB = (MaxIntervals > 1) ? $clog2(MaxIntervals) : 1;
  localparam int CB = $clog2(MaxIntervals + 1);
  localparam logic [1:0] ST_LOAD = 2'd0, ST_PASS = 2'd1, ST_OUT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [CB-1:0] cnt_r, cnt_nxt, pos_r, pos_nxt;
  logic [TimeBits-1:0] b1_r, b1_nxt, b2_r, b2_nxt;
  logic u1_r, u1_nxt, u2_r, u2_nxt, fail_r, fail_nxt;
  logic own_mem [MaxIntervals];
  logic owner_rd_r;
  logic [TimeBits-1:0] cs [MaxIntervals+2];
  logic [TimeBits-1:0] ce [MaxIntervals+2];
  logic [IB-1:0] ci [MaxIntervals+2];
  logic ga [MaxIntervals+1];
  logic cv [MaxIntervals+1];
  logic acc, ins, shift;

  assign in_ch.ready = (state_r == ST_LOAD);
  assign acc = in_ch.valid && in_ch.ready;
  assign ins = acc && (cnt_r < CB'(MaxIntervals));
  assign shift = (state_r == ST_PASS);
  assign ga[0] = 1'b0;
  assign cv[0] = 1'b0;
  assign cs[0] = '0;
  assign ce[0] = '0;
  assign ci[0] = '0;
  assign cs[MaxIntervals+1] = '0;
  assign ce[MaxIntervals+1] = '0;
  assign ci[MaxIntervals+1] = '0;

  for (genvar g = 0; g < MaxIntervals; g++) begin : g_cell
    assign cv[g+1] = CB'(g) < cnt_r;
    tria_cell #(.TimeBits(TimeBits), .IdxBits(IB)) u_cell (
      .clk(clk), .ins(ins), .shift(shift),
      .new_start(in_ch.start_time), .new_end(in_ch.end_time),
      .new_idx(cnt_r[IB-1:0]),
      .prev_goes_after(ga[g]), .prev_start(cs[g]), .prev_end(ce[g]),
      .prev_idx(ci[g]), .prev_valid(cv[g]),
      .next_start(cs[g+2]), .next_end(ce[g+2]), .next_idx(ci[g+2]),
      .valid(cv[g+1]),
      .goes_after(ga[g+1]), .start_r(cs[g+1]), .end_r(ce[g+1]), .idx_r(ci[g+1])
    );
  end

  logic [TimeBits-1:0] hs, he;
  logic [IB-1:0] hi;
  logic fit1, fit2;
  assign hs = cs[1];
  assign he = ce[1];
  assign hi = ci[1];
  assign fit1 = !u1_r || hs >= b1_r;
  assign fit2 = !u2_r || hs >= b2_r;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; pos_nxt = pos_r;
    b1_nxt = b1_r; b2_nxt = b2_r; u1_nxt = u1_r; u2_nxt = u2_r; fail_nxt = fail_r;
    unique case (state_r)
      ST_LOAD: begin
        if (ins) cnt_nxt = cnt_r + 1'b1;
        if (acc && in_ch.last_interval) begin
          state_nxt = ST_PASS;
          pos_nxt = '0;
          fail_nxt = 1'b0;
          b1_nxt = '0; b2_nxt = '0; u1_nxt = 1'b0; u2_nxt = 1'b0;
        end
      end
      ST_PASS: begin
        if (pos_r == cnt_r) begin
          state_nxt = ST_OUT;
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + 1'b1;
          if (!fail_r) begin
            if (fit1) begin u1_nxt = 1'b1; b1_nxt = he; end
            else if (fit2) begin u2_nxt = 1'b1; b2_nxt = he; end
            else fail_nxt = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          if (out_ch.last_result) begin
            state_nxt = ST_LOAD; cnt_nxt = '0;
          end else pos_nxt = pos_r + 1'b1;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; cnt_r <= '0; pos_r <= '0; fail_r <= 1'b0;
      b1_r <= '0; b2_r <= '0; u1_r <= 1'b0; u2_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; pos_r <= pos_nxt; fail_r <= fail_nxt;
      b1_r <= b1_nxt; b2_r <= b2_nxt; u1_r <= u1_nxt; u2_r <= u2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PASS && pos_r != cnt_r && !fail_r)
      own_mem[hi] <= !fit1;
    owner_rd_r <= own_mem[pos_nxt[IB-1:0]];
  end

  logic single;
  assign single = fail_r || cnt_r == '0;
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.impossible = fail_r;
  assign out_ch.owner = single ? 1'b0 : owner_rd_r;
  assign out_ch.last_result = single || (pos_r + 1'b1 == cnt_r);

`ifndef NO_ASSERTIONS
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_LOAD |-> !in_ch.ready) else $error("input ready while busy");
  a_cnt_lim: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CB'(MaxIntervals)) else $error("count overflow");
  a_imp_own: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.impossible |-> !out_ch.owner && out_ch.last_result)
    else $error("bad impossible result");
  a_reset_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last_result |=> cnt_r == '0)
    else $error("count not cleared");
`endif
endmodule
`default_nettype wire
